// File: hw/rtl/c8ie_pkg.sv
// shared types, opcode codes and helper functions of the chip-8 executor
package c8ie_pkg;

	localparam logic [1:0] CMD_EXEC = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_ROW  = 2'd3;

	localparam logic [3:0] OP_SYS  = 4'h0;
	localparam logic [3:0] OP_JP   = 4'h1;
	localparam logic [3:0] OP_CALL = 4'h2;
	localparam logic [3:0] OP_SE   = 4'h3;
	localparam logic [3:0] OP_SNE  = 4'h4;
	localparam logic [3:0] OP_SER  = 4'h5;
	localparam logic [3:0] OP_LD   = 4'h6;
	localparam logic [3:0] OP_ADD  = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8;
	localparam logic [3:0] OP_SNER = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_JPV  = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC;
	localparam logic [3:0] OP_DRW  = 4'hD;
	localparam logic [3:0] OP_KEY  = 4'hE;
	localparam logic [3:0] OP_MISC = 4'hF;

	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	localparam logic [7:0] SYS_CLS  = 8'hE0;
	localparam logic [7:0] SYS_RET  = 8'hEE;
	localparam logic [7:0] KEY_SKP  = 8'h9E;
	localparam logic [7:0] KEY_SKNP = 8'hA1;

	localparam logic [7:0] MSC_GDT   = 8'h07;
	localparam logic [7:0] MSC_KEY   = 8'h0A;
	localparam logic [7:0] MSC_SDT   = 8'h15;
	localparam logic [7:0] MSC_SST   = 8'h18;
	localparam logic [7:0] MSC_ADDI  = 8'h1E;
	localparam logic [7:0] MSC_FONT  = 8'h29;
	localparam logic [7:0] MSC_BCD   = 8'h33;
	localparam logic [7:0] MSC_STORE = 8'h55;
	localparam logic [7:0] MSC_LOAD  = 8'h65;

	localparam logic [3:0]  FLAG_REG = 4'hF;
	localparam logic [11:0] PC_RESET = 12'h200;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDX, ST_RDY, ST_EXEC, ST_WRX, ST_RET, ST_YMOD,
		ST_DRD, ST_DWR, ST_DVF, ST_BRD, ST_BWR, ST_BCD, ST_FIN
	} state_t;

	typedef enum logic [3:0] {
		DC_NONE, DC_LATCH, DC_RDX, DC_RDY, DC_EXEC, DC_WRX, DC_RET, DC_YMOD,
		DC_DRD, DC_DWR, DC_DVF, DC_BRD, DC_BWR, DC_BCD, DC_FIN
	} dcmd_t;

	typedef enum logic [2:0] {
		FL_DONE, FL_WRX, FL_RET, FL_DRAW, FL_STORE, FL_LOAD, FL_BCD
	} flow_t;

	typedef struct packed {
		flow_t flow;
		logic  y_ok;
		logic  no_rows;
		logic  last;
		logic  out_free;
	} dp_status_t;

	// double dabble, three digits
	function automatic logic [11:0] bcd8(input logic [7:0] v);
		logic [19:0] s;
		s = {12'd0, v};
		for (int i = 0; i < 8; i++) begin
			if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
			if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
			if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
			s = s << 1;
		end
		return s[19:8];
	endfunction

	function automatic logic [3:0] lowest_key(input logic [15:0] k);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 15; i >= 0; i--) begin
			if (k[i]) r = 4'(i);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/chip8_instruction_executor.sv
// top level of the chip-8 instruction executor
// Runs one command per input beat (execute an opcode, load a memory byte,
// tick the timers, read a display row) and returns one result beat with
// the PC, index, VF, key-wait and sound status, and the row for a row read.
// Items are handled one at a time through a simple dual-port register file,
// main memory and framebuffer memory. A plain command steps through accept,
// read Vx, read Vy, execute and finish; an ALU op that sets VF adds a write of
// Vx and a return adds a stack read; a sprite draw adds Vy wrapping steps (one
// more per SCREEN_HEIGHT that Vy exceeds), a read and a write per row and a VF
// write; FX55 and FX65 add a read and a write per register V0..VX; FX33 adds a
// memory write per digit. A new item is accepted while the last result still
// waits. Reset clears the framebuffer at once through per-row valid bits, so no clearing pass is needed.
module chip8_instruction_executor #(
	parameter int MEM_DEPTH       = 4096,
	parameter int STACK_DEPTH     = 16,
	parameter int MAX_SPRITE_ROWS = 15,
	parameter int SCREEN_HEIGHT   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] opcode,
	input  logic [7:0]  random_byte,
	input  logic [15:0] keys_down,
	input  logic [11:0] location,
	input  logic [7:0]  load_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] program_counter,
	output logic [15:0] index_value,
	output logic [7:0]  flag_value,
	output logic        waiting_for_key,
	output logic        sound_active,
	output logic [63:0] row_pixels
);
	import c8ie_pkg::*;

	dcmd_t      dcmd;
	dp_status_t status;

	c8ie_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .dcmd(dcmd)
	);

	c8ie_dp #(
		.MEM_DEPTH(MEM_DEPTH), .STACK_DEPTH(STACK_DEPTH),
		.MAX_SPRITE_ROWS(MAX_SPRITE_ROWS), .SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .dcmd(dcmd), .status(status),
		.command(command), .opcode(opcode), .random_byte(random_byte),
		.keys_down(keys_down), .location(location), .load_byte(load_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.program_counter(program_counter), .index_value(index_value),
		.flag_value(flag_value), .waiting_for_key(waiting_for_key),
		.sound_active(sound_active), .row_pixels(row_pixels)
	);
endmodule

// File: hw/rtl/c8ie_ram.sv
// generic simple dual-port ram with registered read
module c8ie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: hw/rtl/c8ie_ctrl.sv
// sequencing state machine of the chip-8 executor
module c8ie_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  c8ie_pkg::dp_status_t   status,
	output c8ie_pkg::dcmd_t        dcmd
);
	import c8ie_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		dcmd     = DC_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dcmd    = DC_LATCH;
					state_d = ST_RDX;
				end
			end
			ST_RDX: begin
				dcmd    = DC_RDX;
				state_d = ST_RDY;
			end
			ST_RDY: begin
				dcmd    = DC_RDY;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				dcmd = DC_EXEC;
				unique case (status.flow)
					FL_DONE:  state_d = ST_FIN;
					FL_WRX:   state_d = ST_WRX;
					FL_RET:   state_d = ST_RET;
					FL_DRAW:  state_d = ST_YMOD;
					FL_STORE: state_d = ST_BRD;
					FL_LOAD:  state_d = ST_BRD;
					FL_BCD:   state_d = ST_BCD;
					default:  state_d = ST_FIN;
				endcase
			end
			ST_WRX: begin
				dcmd    = DC_WRX;
				state_d = ST_FIN;
			end
			ST_RET: begin
				dcmd    = DC_RET;
				state_d = ST_FIN;
			end
			ST_YMOD: begin
				dcmd = DC_YMOD;
				if (status.y_ok) state_d = status.no_rows ? ST_DVF : ST_DRD;
			end
			ST_DRD: begin
				dcmd    = DC_DRD;
				state_d = ST_DWR;
			end
			ST_DWR: begin
				dcmd    = DC_DWR;
				state_d = status.last ? ST_DVF : ST_DRD;
			end
			ST_DVF: begin
				dcmd    = DC_DVF;
				state_d = ST_FIN;
			end
			ST_BRD: begin
				dcmd    = DC_BRD;
				state_d = ST_BWR;
			end
			ST_BWR: begin
				dcmd    = DC_BWR;
				state_d = status.last ? ST_FIN : ST_BRD;
			end
			ST_BCD: begin
				dcmd = DC_BCD;
				if (status.last) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					dcmd    = DC_FIN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// File: hw/rtl/c8ie_dp.sv
// datapath of the chip-8 executor: registers, memories, alu and output beat
module c8ie_dp #(
	parameter int MEM_DEPTH       = 4096,
	parameter int STACK_DEPTH     = 16,
	parameter int MAX_SPRITE_ROWS = 15,
	parameter int SCREEN_HEIGHT   = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c8ie_pkg::dcmd_t      dcmd,
	output c8ie_pkg::dp_status_t status,
	input  logic [1:0]           command,
	input  logic [15:0]          opcode,
	input  logic [7:0]           random_byte,
	input  logic [15:0]          keys_down,
	input  logic [11:0]          location,
	input  logic [7:0]           load_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [11:0]          program_counter,
	output logic [15:0]          index_value,
	output logic [7:0]           flag_value,
	output logic                 waiting_for_key,
	output logic                 sound_active,
	output logic [63:0]          row_pixels
);
	import c8ie_pkg::*;

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int RW = $clog2(SCREEN_HEIGHT);
	localparam logic [SW-1:0] SP_LAST  = SW'(STACK_DEPTH - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_HEIGHT - 1);
	localparam logic [7:0]    FH8      = 8'(SCREEN_HEIGHT);
	localparam logic [11:0]   FH12     = 12'(SCREEN_HEIGHT);
	localparam logic [3:0]    MAXR     = 4'(MAX_SPRITE_ROWS);

	logic [1:0]  cmd_q;
	logic [15:0] op_q, keys_q, i_q;
	logic [7:0]  rnd_q, lbyte_q, vx_q, res_q, dt_q, st_q, vf_q, ymod_q;
	logic [11:0] loc_q, pc_q;
	logic [SW-1:0] sp_q;
	logic        wait_q, hit_q;
	logic [3:0]  cnt_q, nrows_q, rf_ra_q;
	logic [RW-1:0] row_q, fr_ra_q;
	flow_t       flow_q;
	logic [15:0] rf_valid_q;
	logic [SCREEN_HEIGHT-1:0] fvalid_q;
	logic        out_valid_q, o_wait_q, o_snd_q;
	logic [11:0] o_pc_q;
	logic [15:0] o_i_q;
	logic [7:0]  o_vf_q;
	logic [63:0] o_row_q;

	logic [3:0]  grp, x, y, n;
	logic [7:0]  nn;
	logic [11:0] nnn, pc2, pc4;
	logic [7:0]  vx, vy, rf_rd, rf_rdata, mem_rdata;
	logic [63:0] fr_rd, fr_rdata, mask, new_row;
	logic [127:0] rot;
	logic [11:0] st_rdata, bcd;
	logic [16:0] mem_ia, loc_a;
	logic [8:0]  add9;
	logic        key_hit;
	logic [SW-1:0] sp_inc, sp_dec;
	logic [7:0]  digit;

	logic          rf_we, rf_re, mem_we, mem_re, stk_we, stk_re, fr_we, fr_re;
	logic [3:0]    rf_waddr, rf_raddr;
	logic [7:0]    rf_wdata, mem_wdata;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [SW-1:0] stk_waddr, stk_raddr;
	logic [RW-1:0] fr_waddr, fr_raddr;

	logic        ex_we, ex_wait, ex_cls, ex_push, ex_pop;
	logic [3:0]  ex_wa;
	logic [7:0]  ex_wd, ex_res, ex_dt, ex_st;
	logic [11:0] ex_pc;
	logic [15:0] ex_i;
	flow_t       ex_flow;

	assign grp = op_q[15:12];
	assign x   = op_q[11:8];
	assign y   = op_q[7:4];
	assign n   = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];
	assign pc2 = pc_q + 12'd2;
	assign pc4 = pc_q + 12'd4;

	assign rf_rd  = rf_valid_q[rf_ra_q] ? rf_rdata : 8'd0;
	assign fr_rd  = fvalid_q[fr_ra_q] ? fr_rdata : 64'd0;
	assign vx     = vx_q;
	assign vy     = rf_rd;
	assign add9   = {1'b0, vx} + {1'b0, vy};
	assign key_hit = (vx[7:4] == 4'd0) && keys_q[vx[3:0]];
	assign mem_ia = {1'b0, i_q} + {13'd0, cnt_q};
	assign loc_a  = {5'd0, loc_q};
	assign sp_inc = (sp_q == SP_LAST) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SP_LAST : sp_q - 1'b1;
	assign bcd    = bcd8(vx_q);
	assign rot    = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> vx_q[5:0];
	assign mask   = rot[63:0];
	assign new_row = fr_rd ^ mask;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    digit = {4'd0, bcd[11:8]};
			2'd1:    digit = {4'd0, bcd[7:4]};
			default: digit = {4'd0, bcd[3:0]};
		endcase
	end

	// single-beat work of an item
	always_comb begin
		ex_we   = 1'b0;
		ex_wa   = x;
		ex_wd   = 8'd0;
		ex_res  = 8'd0;
		ex_pc   = pc_q;
		ex_i    = i_q;
		ex_dt   = dt_q;
		ex_st   = st_q;
		ex_wait = 1'b0;
		ex_cls  = 1'b0;
		ex_push = 1'b0;
		ex_pop  = 1'b0;
		ex_flow = FL_DONE;
		case (cmd_q)
			CMD_EXEC: begin
				ex_pc = pc2;
				unique case (grp)
					OP_SYS: begin
						if (nn == SYS_CLS) ex_cls = 1'b1;
						else if (nn == SYS_RET) begin
							ex_pop  = 1'b1;
							ex_flow = FL_RET;
						end
					end
					OP_JP: ex_pc = nnn;
					OP_CALL: begin
						ex_push = 1'b1;
						ex_pc   = nnn;
					end
					OP_SE:   ex_pc = (vx == nn) ? pc4 : pc2;
					OP_SNE:  ex_pc = (vx != nn) ? pc4 : pc2;
					OP_SER:  ex_pc = (vx == vy) ? pc4 : pc2;
					OP_SNER: ex_pc = (vx != vy) ? pc4 : pc2;
					OP_LD: begin
						ex_we = 1'b1;
						ex_wd = nn;
					end
					OP_ADD: begin
						ex_we = 1'b1;
						ex_wd = vx + nn;
					end
					OP_ALU: begin
						unique case (n)
							ALU_MOV: begin ex_we = 1'b1; ex_wd = vy; end
							ALU_OR:  begin ex_we = 1'b1; ex_wd = vx | vy; end
							ALU_AND: begin ex_we = 1'b1; ex_wd = vx & vy; end
							ALU_XOR: begin ex_we = 1'b1; ex_wd = vx ^ vy; end
							ALU_ADD: begin
								ex_we = 1'b1; ex_wa = FLAG_REG; ex_wd = {7'd0, add9[8]};
								ex_res = add9[7:0]; ex_flow = FL_WRX;
							end
							ALU_SUB: begin
								ex_we = 1'b1; ex_wa = FLAG_REG; ex_wd = {7'd0, vx > vy};
								ex_res = vx - vy; ex_flow = FL_WRX;
							end
							ALU_SHR: begin
								ex_we = 1'b1; ex_wa = FLAG_REG; ex_wd = {7'd0, vx[0]};
								ex_res = {1'b0, vx[7:1]}; ex_flow = FL_WRX;
							end
							ALU_SUBN: begin
								ex_we = 1'b1; ex_wa = FLAG_REG; ex_wd = {7'd0, vy > vx};
								ex_res = vy - vx; ex_flow = FL_WRX;
							end
							ALU_SHL: begin
								ex_we = 1'b1; ex_wa = FLAG_REG; ex_wd = {7'd0, vx[7]};
								ex_res = {vx[6:0], 1'b0}; ex_flow = FL_WRX;
							end
							default: ;
						endcase
					end
					OP_LDI: ex_i = {4'd0, nnn};
					OP_JPV: ex_pc = nnn + {4'd0, vx};
					OP_RND: begin
						ex_we = 1'b1;
						ex_wd = rnd_q & nn;
					end
					OP_DRW: ex_flow = FL_DRAW;
					OP_KEY: begin
						if (nn == KEY_SKP) ex_pc = key_hit ? pc4 : pc2;
						else if (nn == KEY_SKNP) ex_pc = key_hit ? pc2 : pc4;
					end
					OP_MISC: begin
						unique case (nn)
							MSC_GDT: begin ex_we = 1'b1; ex_wd = dt_q; end
							MSC_KEY: begin
								if (keys_q != 16'd0) begin
									ex_we = 1'b1;
									ex_wd = {4'd0, lowest_key(keys_q)};
								end else begin
									ex_pc   = pc_q;
									ex_wait = 1'b1;
								end
							end
							MSC_SDT:   ex_dt = vx;
							MSC_SST:   ex_st = vx;
							MSC_ADDI:  ex_i = i_q + {8'd0, vx};
							MSC_FONT:  ex_i = {6'd0, vx, 2'd0} + {8'd0, vx};
							MSC_BCD:   ex_flow = FL_BCD;
							MSC_STORE: ex_flow = FL_STORE;
							MSC_LOAD:  ex_flow = FL_LOAD;
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			CMD_TICK: begin
				ex_dt = (dt_q != 8'd0) ? dt_q - 8'd1 : dt_q;
				ex_st = (st_q != 8'd0) ? st_q - 8'd1 : st_q;
			end
			default: ;
		endcase
	end

	// memory port selection
	always_comb begin
		rf_we = 1'b0; rf_waddr = x; rf_wdata = 8'd0; rf_re = 1'b0; rf_raddr = x;
		mem_we = 1'b0; mem_waddr = mem_ia[AW-1:0]; mem_wdata = 8'd0;
		mem_re = 1'b0; mem_raddr = mem_ia[AW-1:0];
		stk_we = 1'b0; stk_waddr = sp_q; stk_re = 1'b0; stk_raddr = sp_dec;
		fr_we = 1'b0; fr_waddr = row_q; fr_re = 1'b0; fr_raddr = row_q;
		unique case (dcmd)
			DC_RDX: begin
				rf_re    = 1'b1;
				rf_raddr = (grp == OP_JPV) ? 4'd0 : x;
			end
			DC_RDY: begin
				rf_re    = 1'b1;
				rf_raddr = y;
			end
			DC_EXEC: begin
				rf_we    = ex_we;
				rf_waddr = ex_wa;
				rf_wdata = ex_wd;
				stk_we   = ex_push;
				stk_re   = ex_pop;
				if (cmd_q == CMD_LOAD) begin
					mem_we    = 1'b1;
					mem_waddr = loc_a[AW-1:0];
					mem_wdata = lbyte_q;
				end
				if (cmd_q == CMD_ROW) begin
					fr_re    = 1'b1;
					fr_raddr = loc_q[RW-1:0];
				end
			end
			DC_WRX: begin
				rf_we    = 1'b1;
				rf_wdata = res_q;
			end
			DC_DRD: begin
				mem_re = 1'b1;
				fr_re  = 1'b1;
			end
			DC_DWR: fr_we = 1'b1;
			DC_DVF: begin
				rf_we    = 1'b1;
				rf_waddr = FLAG_REG;
				rf_wdata = {7'd0, hit_q};
			end
			DC_BRD: begin
				if (flow_q == FL_STORE) begin
					rf_re    = 1'b1;
					rf_raddr = cnt_q;
				end else mem_re = 1'b1;
			end
			DC_BWR: begin
				if (flow_q == FL_STORE) begin
					mem_we    = 1'b1;
					mem_wdata = rf_rd;
				end else begin
					rf_we    = 1'b1;
					rf_waddr = cnt_q;
					rf_wdata = mem_rdata;
				end
			end
			DC_BCD: begin
				mem_we    = 1'b1;
				mem_wdata = digit;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0; op_q <= '0; rnd_q <= '0; keys_q <= '0; loc_q <= '0;
			lbyte_q <= '0; vx_q <= '0; res_q <= '0; pc_q <= PC_RESET; i_q <= '0;
			sp_q <= '0; dt_q <= '0; st_q <= '0; vf_q <= '0; wait_q <= 1'b0;
			hit_q <= 1'b0; cnt_q <= '0; nrows_q <= '0; ymod_q <= '0; row_q <= '0;
			flow_q <= FL_DONE; rf_valid_q <= '0; rf_ra_q <= '0; fvalid_q <= '0;
			fr_ra_q <= '0; out_valid_q <= 1'b0; o_pc_q <= '0; o_i_q <= '0;
			o_vf_q <= '0; o_wait_q <= 1'b0; o_snd_q <= 1'b0; o_row_q <= '0;
		end else begin
			if (dcmd == DC_FIN) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (rf_we) begin
				rf_valid_q[rf_waddr] <= 1'b1;
				if (rf_waddr == FLAG_REG) vf_q <= rf_wdata;
			end
			if (rf_re) rf_ra_q <= rf_raddr;
			if (fr_re) fr_ra_q <= fr_raddr;
			if (fr_we) fvalid_q[fr_waddr] <= 1'b1;
			case (dcmd)
				DC_LATCH: begin
					cmd_q   <= command;
					op_q    <= opcode;
					rnd_q   <= random_byte;
					keys_q  <= keys_down;
					loc_q   <= location;
					lbyte_q <= load_byte;
					wait_q  <= 1'b0;
				end
				DC_RDY: vx_q <= rf_rd;
				DC_EXEC: begin
					pc_q    <= ex_pc;
					i_q     <= ex_i;
					dt_q    <= ex_dt;
					st_q    <= ex_st;
					wait_q  <= ex_wait;
					res_q   <= ex_res;
					flow_q  <= ex_flow;
					cnt_q   <= '0;
					hit_q   <= 1'b0;
					ymod_q  <= vy;
					nrows_q <= (n > MAXR) ? MAXR : n;
					if (ex_cls) fvalid_q <= '0;
					if (ex_push) sp_q <= sp_inc;
					if (ex_pop) sp_q <= sp_dec;
				end
				DC_RET: pc_q <= st_rdata + 12'd2;
				DC_YMOD: begin
					if (ymod_q >= FH8) ymod_q <= ymod_q - FH8;
					else row_q <= ymod_q[RW-1:0];
				end
				DC_DWR: begin
					hit_q <= hit_q | (|(fr_rd & mask));
					cnt_q <= cnt_q + 4'd1;
					row_q <= (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
				end
				DC_BWR, DC_BCD: cnt_q <= cnt_q + 4'd1;
				DC_FIN: begin
					o_pc_q      <= pc_q;
					o_i_q       <= i_q;
					o_vf_q      <= vf_q;
					o_wait_q    <= wait_q;
					o_snd_q     <= (st_q != 8'd0);
					o_row_q     <= (cmd_q == CMD_ROW && loc_q < FH12) ? fr_rd : 64'd0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		status.flow     = ex_flow;
		status.y_ok     = (ymod_q < FH8);
		status.no_rows  = (nrows_q == 4'd0);
		status.out_free = !out_valid_q || out_ready;
		case (flow_q)
			FL_DRAW: status.last = (cnt_q == nrows_q - 4'd1);
			FL_BCD:  status.last = (cnt_q == 4'd2);
			default: status.last = (cnt_q == x);
		endcase
	end

	c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(rf_re), .raddr(rf_raddr), .rdata(rf_rdata)
	);

	c8ie_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(pc_q),
		.re(stk_re), .raddr(stk_raddr), .rdata(st_rdata)
	);

	c8ie_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_frame (
		.clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(new_row),
		.re(fr_re), .raddr(fr_raddr), .rdata(fr_rdata)
	);

	assign out_valid       = out_valid_q;
	assign program_counter = o_pc_q;
	assign index_value     = o_i_q;
	assign flag_value      = o_vf_q;
	assign waiting_for_key = o_wait_q;
	assign sound_active    = o_snd_q;
	assign row_pixels      = o_row_q;
endmodule
